FILE: src/wsi_pkg.sv
// Shared types, codes and constants of the waypoint setpoint interpolator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package wsi_pkg;

    localparam int MAX_WAYPOINTS_DEF = 64;

    localparam logic [30:0] STEP_RST = 31'd6554;
    localparam logic [30:0] PTOL_RST = 31'd6554;
    localparam logic [14:0] YTOL_RST = 15'd819;

    localparam logic signed [17:0] YAW_PI     = 18'sd25736;
    localparam logic signed [17:0] YAW_TWO_PI = 18'sd51472;
    localparam logic [30:0]        DIST_SAT   = 31'h7FFF_FFFF;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_CANCEL = 2'd3;

    // status codes
    localparam logic [1:0] ST_PROGRESS = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_CANCEL   = 2'd2;
    localparam logic [1:0] ST_REJECT   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_STEP = 2'd0;
    localparam logic [1:0] CFG_PTOL = 2'd1;
    localparam logic [1:0] CFG_YTOL = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] way_x;
        logic signed [31:0] way_y;
        logic signed [31:0] way_z;
        logic signed [15:0] way_heading;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         active_index;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [15:0] target_heading;
        logic [30:0]        distance_to_goal;
    } t_out;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] h;
    } t_wp;

    // handshake of an iterative unit
    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_START, S_SQ0, S_SQ1, S_SQ2, S_SQ3,
        S_SQRT, S_MUL, S_DIV, S_DIVW
    } t_state;

    typedef enum logic [1:0] {
        PH_START, PH_TICK, PH_PERR, PH_GOAL
    } t_phase;

    // single fold into [-pi, pi]; inputs stay within one turn of that range
    function automatic logic signed [17:0] wrap_yaw(input logic signed [17:0] a);
        logic signed [17:0] r;
        r = a;
        if (a > YAW_PI) begin
            r = a - YAW_TWO_PI;
        end else if (a < -YAW_PI) begin
            r = a + YAW_TWO_PI;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/wsi_sqrt.sv
// Bit-serial integer square root, floor(sqrt) of a 66-bit radicand.
// Depends on wsi_pkg for the unit handshake struct.
`default_nettype none

module wsi_sqrt
    import wsi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [65:0] i_radicand,
    output t_unit_ctl        o_ctl,
    output logic [32:0]      o_root
);

    logic [65:0] r_x,    n_x;
    logic [36:0] r_rem,  n_rem;
    logic [32:0] r_root, n_root;
    logic [5:0]  r_cnt,  n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [36:0] rem_sh, trial;

    always_comb begin
        rem_sh = {r_rem[34:0], r_x[65:64]};
        trial  = {2'b00, r_root, 2'b01};
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_x    = i_radicand;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = 6'd33;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_x = {r_x[63:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[31:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[31:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_ctl.start = i_start;
    assign o_ctl.done  = r_done;
    assign o_root      = r_root;

endmodule

`default_nettype wire

FILE: src/wsi_div.sv
// Restoring divider, 64-bit numerator by 33-bit divisor, 32-bit quotient;
// the caller keeps the quotient below 2^32. Depends on wsi_pkg.
`default_nettype none

module wsi_div
    import wsi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [32:0] i_den,
    output t_unit_ctl        o_ctl,
    output logic [31:0]      o_quo
);

    logic [32:0] r_rem,  n_rem;
    logic [31:0] r_lo,   n_lo;
    logic [32:0] r_den,  n_den;
    logic [5:0]  r_cnt,  n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [33:0] rem2;

    always_comb begin
        rem2   = {r_rem, r_lo[31]};
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = {1'b0, i_num[63:32]};
            n_lo   = i_num[31:0];
            n_den  = i_den;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem2 >= {1'b0, r_den}) begin
                n_rem = 33'(rem2 - {1'b0, r_den});
                n_lo  = {r_lo[30:0], 1'b1};
            end else begin
                n_rem = rem2[32:0];
                n_lo  = {r_lo[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_den <= n_den;
    end

    assign o_ctl.start = i_start;
    assign o_ctl.done  = r_done;
    assign o_quo       = r_lo;

endmodule

`default_nettype wire

FILE: src/waypoint_setpoint_interpolator_top.sv
// Waypoint setpoint interpolator. Append items fill a waypoint table held in
// a memory; a start item puts the setpoint on waypoint 0 and each tick moves
// it up to step_length toward the current waypoint. One item is handled at a
// time and the input stalls while it runs or while a result waits. A tick
// makes three distance evaluations (shared 32x32 multiplier plus a
// bit-serial square root) and, when the setpoint steps rather than snaps,
// four divisions (divider per axis and yaw); a running cancel makes one
// distance evaluation.
// Depends on wsi_pkg, wsi_sqrt and wsi_div.
`default_nettype none

module waypoint_setpoint_interpolator_top
    import wsi_pkg::*;
#(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out             o_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WAYPOINTS);

    t_wp r_mem [MAX_WAYPOINTS];
    t_wp r_rd;

    t_state             r_state,  n_state;
    t_phase             r_phase,  n_phase;
    logic [AW:0]        r_count,  n_count;
    logic [AW-1:0]      r_seg,    n_seg;
    logic               r_active, n_active;
    logic signed [31:0] r_sp_x,   n_sp_x;
    logic signed [31:0] r_sp_y,   n_sp_y;
    logic signed [31:0] r_sp_z,   n_sp_z;
    logic signed [15:0] r_sp_h,   n_sp_h;
    logic [30:0]        r_step,   r_ptol;
    logic [14:0]        r_ytol;
    logic [63:0]        r_prod;
    logic [65:0]        r_acc,    n_acc;
    logic [32:0]        r_dist,   n_dist;
    logic signed [15:0] r_yerr,   n_yerr;
    logic [1:0]         r_ax,     n_ax;
    logic [1:0]         r_status, n_status;
    logic               r_ov,     n_ov;
    t_out               r_out,    n_out;

    logic               accept, wr_en;
    logic [AW-1:0]      rd_addr;
    logic signed [32:0] dx, dy, dz;
    logic [31:0]        mx, my, mz, mul_a, mul_b;
    logic [15:0]        yerr_mag;
    logic signed [17:0] yerr_w, hsum;
    logic [31:0]        q;
    logic               sqrt_go, div_go;
    t_unit_ctl          sqrt_ctl, div_ctl;
    logic [32:0]        root;

    assign accept      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE) || r_ov;
    assign o_valid     = r_ov;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    // differences from the setpoint to the waypoint currently read
    assign dx = {r_rd.x[31], r_rd.x} - {r_sp_x[31], r_sp_x};
    assign dy = {r_rd.y[31], r_rd.y} - {r_sp_y[31], r_sp_y};
    assign dz = {r_rd.z[31], r_rd.z} - {r_sp_z[31], r_sp_z};
    assign mx = dx[32] ? 32'(-dx) : dx[31:0];
    assign my = dy[32] ? 32'(-dy) : dy[31:0];
    assign mz = dz[32] ? 32'(-dz) : dz[31:0];
    assign yerr_w = wrap_yaw({{2{r_rd.h[15]}}, r_rd.h} - {{2{r_sp_h[15]}}, r_sp_h});
    assign yerr_mag = yerr_w[17] ? 16'(-yerr_w) : yerr_w[15:0];

    always_comb begin
        unique case (r_phase)
            PH_START: rd_addr = '0;
            PH_GOAL:  rd_addr = AW'(r_count - (AW+1)'(1));
            default:  rd_addr = r_seg;
        endcase
    end

    // shared multiplier
    always_comb begin
        mul_a = mx;
        mul_b = mx;
        unique case (r_state)
            S_SQ1: begin
                mul_a = my;
                mul_b = my;
            end
            S_SQ2: begin
                mul_a = mz;
                mul_b = mz;
            end
            S_MUL: begin
                mul_b = {1'b0, r_step};
                case (r_ax)
                    2'd0:    mul_a = mx;
                    2'd1:    mul_a = my;
                    2'd2:    mul_a = mz;
                    default: mul_a = {16'd0, r_yerr[15] ? 16'(-r_yerr) : r_yerr};
                endcase
            end
            default: begin
                mul_a = mx;
                mul_b = mx;
            end
        endcase
    end

    wsi_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_go),
        .i_radicand (r_acc + 66'(r_prod)),
        .o_ctl      (sqrt_ctl),
        .o_root     (root)
    );

    wsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (r_prod),
        .i_den   (r_dist),
        .o_ctl   (div_ctl),
        .o_quo   (q)
    );

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_count  = r_count;
        n_seg    = r_seg;
        n_active = r_active;
        n_sp_x   = r_sp_x;
        n_sp_y   = r_sp_y;
        n_sp_z   = r_sp_z;
        n_sp_h   = r_sp_h;
        n_acc    = r_acc;
        n_dist   = r_dist;
        n_yerr   = r_yerr;
        n_ax     = r_ax;
        n_status = r_status;
        n_ov     = r_ov;
        n_out    = r_out;
        wr_en    = 1'b0;
        sqrt_go  = 1'b0;
        div_go   = 1'b0;
        hsum     = '0;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_data.operation)
                        OP_APPEND: begin
                            if (!r_active && r_count != (AW+1)'(MAX_WAYPOINTS)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + (AW+1)'(1);
                            end
                        end
                        OP_START: begin
                            if (r_count == '0 || r_active) begin
                                n_out        = '0;
                                n_out.status = ST_REJECT;
                                n_ov         = 1'b1;
                            end else begin
                                n_phase = PH_START;
                                n_state = S_FETCH;
                            end
                        end
                        OP_TICK: begin
                            if (r_active) begin
                                n_phase = PH_TICK;
                                n_state = S_FETCH;
                            end
                        end
                        OP_CANCEL: begin
                            if (r_active) begin
                                n_status = ST_CANCEL;
                                n_phase  = PH_GOAL;
                                n_state  = S_FETCH;
                            end else begin
                                n_count = '0;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FETCH: begin
                n_state = (r_phase == PH_START) ? S_START : S_SQ0;
            end
            S_START: begin
                n_active = 1'b1;
                n_seg    = '0;
                n_sp_x   = r_rd.x;
                n_sp_y   = r_rd.y;
                n_sp_z   = r_rd.z;
                n_sp_h   = r_rd.h;
                n_state  = S_IDLE;
            end
            S_SQ0: n_state = S_SQ1;
            S_SQ1: begin
                n_acc   = 66'(r_prod);
                n_state = S_SQ2;
            end
            S_SQ2: begin
                n_acc   = r_acc + 66'(r_prod);
                n_state = S_SQ3;
            end
            S_SQ3: begin
                sqrt_go = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (sqrt_ctl.done) begin
                    unique case (r_phase)
                        PH_TICK: begin
                            n_dist = root;
                            n_yerr = yerr_w[15:0];
                            if (root > {2'b00, r_step}) begin
                                n_ax    = 2'd0;
                                n_state = S_MUL;
                            end else begin
                                // within one step: snap onto the waypoint
                                n_sp_x  = r_rd.x;
                                n_sp_y  = r_rd.y;
                                n_sp_z  = r_rd.z;
                                n_sp_h  = 16'(wrap_yaw({{2{r_rd.h[15]}}, r_rd.h}));
                                n_phase = PH_PERR;
                                n_state = S_SQ0;
                            end
                        end
                        PH_PERR: begin
                            n_status = ST_PROGRESS;
                            if (root <= {2'b00, r_ptol} &&
                                yerr_mag <= {1'b0, r_ytol}) begin
                                if ((AW+1)'(r_seg) + (AW+1)'(1) < r_count) begin
                                    n_seg = r_seg + AW'(1);
                                end else begin
                                    n_status = ST_DONE;
                                end
                            end
                            n_phase = PH_GOAL;
                            n_state = S_FETCH;
                        end
                        default: begin
                            n_out.status           = r_status;
                            n_out.active_index     = 6'({6'd0, r_seg});
                            n_out.target_x         = r_sp_x;
                            n_out.target_y         = r_sp_y;
                            n_out.target_z         = r_sp_z;
                            n_out.target_heading   = r_sp_h;
                            n_out.distance_to_goal = (root[32:31] != 2'b00) ?
                                                     DIST_SAT : root[30:0];
                            n_ov = 1'b1;
                            if (r_status == ST_DONE || r_status == ST_CANCEL) begin
                                n_count  = '0;
                                n_active = 1'b0;
                            end
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                div_go  = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (div_ctl.done) begin
                    case (r_ax)
                        2'd0: n_sp_x = dx[32] ? r_sp_x - q : r_sp_x + q;
                        2'd1: n_sp_y = dy[32] ? r_sp_y - q : r_sp_y + q;
                        2'd2: n_sp_z = dz[32] ? r_sp_z - q : r_sp_z + q;
                        default: begin
                            hsum = r_yerr[15] ?
                                   {{2{r_sp_h[15]}}, r_sp_h} - 18'(q[15:0]) :
                                   {{2{r_sp_h[15]}}, r_sp_h} + 18'(q[15:0]);
                            n_sp_h = 16'(wrap_yaw(hsum));
                        end
                    endcase
                    if (r_ax == 2'd3) begin
                        n_phase = PH_PERR;
                        n_state = S_SQ0;
                    end else begin
                        n_ax    = r_ax + 2'd1;
                        n_state = S_MUL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_TICK;
            r_count  <= '0;
            r_seg    <= '0;
            r_active <= 1'b0;
            r_sp_x   <= '0;
            r_sp_y   <= '0;
            r_sp_z   <= '0;
            r_sp_h   <= '0;
            r_ov     <= 1'b0;
            r_step   <= STEP_RST;
            r_ptol   <= PTOL_RST;
            r_ytol   <= YTOL_RST;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_seg    <= n_seg;
            r_active <= n_active;
            r_sp_x   <= n_sp_x;
            r_sp_y   <= n_sp_y;
            r_sp_z   <= n_sp_z;
            r_sp_h   <= n_sp_h;
            r_ov     <= n_ov;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STEP: r_step <= i_cfg_data[30:0];
                    CFG_PTOL: r_ptol <= i_cfg_data[30:0];
                    CFG_YTOL: r_ytol <= i_cfg_data[14:0];
                    default:  r_step <= r_step;
                endcase
            end
        end
        r_prod   <= mul_a * mul_b;
        r_acc    <= n_acc;
        r_dist   <= n_dist;
        r_yerr   <= n_yerr;
        r_ax     <= n_ax;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // waypoint table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= '{x: i_data.way_x, y: i_data.way_y,
                                        z: i_data.way_z, h: i_data.way_heading};
        end
        r_rd <= r_mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: src/wsi_chk.sv
// Port-level checker for the waypoint setpoint interpolator, bound to the top.
// Depends on wsi_pkg and waypoint_setpoint_interpolator_top.
`default_nettype none

module wsi_chk
    import wsi_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire t_in         i_data,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire t_out        o_data,
    input wire logic        i_cfg_valid,
    input wire logic        o_cfg_ready,
    input wire logic [1:0]  i_cfg_index,
    input wire logic [31:0] i_cfg_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result dropped or changed while stalled");

    // no new request while a result waits
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result is pending");

    // a result appears only after a request or while busy
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall) || $past(i_valid))
        else $error("result without a request");

    // a rejected start carries nothing else
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_REJECT |->
            o_data.active_index == '0 && o_data.target_x == '0 &&
            o_data.target_y == '0 && o_data.target_z == '0 &&
            o_data.target_heading == '0 && o_data.distance_to_goal == '0)
        else $error("rejected start with nonzero fields");

endmodule

bind waypoint_setpoint_interpolator_top wsi_chk u_wsi_chk (.*);

`default_nettype wire

FILE: dv/wsi_setpoint_checker.sv
// Checker for the waypoint setpoint interpolator: watches the request, result
// and register channels, predicts each result and compares it field by field.
// Depends on wsi_pkg for the payload types and the operation/status codes.
`default_nettype none

module wsi_setpoint_checker
    import wsi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_stall,
    input  wire t_in         i_data,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire t_out        o_data,
    input  wire logic        i_cfg_valid,
    input  wire logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked,
    output logic             o_path_busy
);

    localparam int TABLE_DEPTH = 64;

    longint          wp_x [TABLE_DEPTH];
    longint          wp_y [TABLE_DEPTH];
    longint          wp_z [TABLE_DEPTH];
    int              wp_h [TABLE_DEPTH];
    int unsigned     wp_count;
    int unsigned     cur_seg;
    longint          sp_x, sp_y, sp_z;
    int              sp_h;
    bit              running;
    longint unsigned step_len, pos_tol, yaw_tol;

    t_out setpoint_q[$];

    function automatic longint unsigned mag64(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // floor of the Euclidean distance; each difference fits in 33 bits
    function automatic longint unsigned distance3(longint dx, longint dy, longint dz);
        logic [69:0] acc;
        logic [69:0] sq;
        logic [34:0] root;
        logic [34:0] trial;
        acc  = 70'(mag64(dx)) * 70'(mag64(dx));
        acc += 70'(mag64(dy)) * 70'(mag64(dy));
        acc += 70'(mag64(dz)) * 70'(mag64(dz));
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            trial = root | (35'd1 << b);
            sq = 70'(trial) * 70'(trial);
            if (sq <= acc) begin
                root = trial;
            end
        end
        return longint'(root);
    endfunction

    function automatic int fold_yaw(int a);
        int r;
        r = a;
        while (r > 25736) r -= 51472;
        while (r < -25736) r += 51472;
        return r;
    endfunction

    function automatic longint slide(longint s, longint d, longint unsigned seg_len);
        longint unsigned q;
        q = mag64(d) * step_len / seg_len;
        return (d < 0) ? s - longint'(q) : s + longint'(q);
    endfunction

    function automatic t_out snapshot(logic [1:0] status);
        t_out            r;
        int unsigned     last;
        longint unsigned dg;
        last = wp_count - 1;
        dg = distance3(wp_x[last] - sp_x, wp_y[last] - sp_y, wp_z[last] - sp_z);
        if (dg > 64'(DIST_SAT)) begin
            dg = 64'(DIST_SAT);
        end
        r.status           = status;
        r.active_index     = cur_seg[5:0];
        r.target_x         = sp_x[31:0];
        r.target_y         = sp_y[31:0];
        r.target_z         = sp_z[31:0];
        r.target_heading   = sp_h[15:0];
        r.distance_to_goal = dg[30:0];
        return r;
    endfunction

    task automatic advance_setpoint(input t_in req, output bit has, output t_out r);
        longint          dx, dy, dz;
        longint unsigned seg_len, perr;
        int              yerr, yabs, q;
        has = 1'b0;
        r   = '0;
        case (req.operation)
            OP_APPEND: begin
                if (!running && wp_count < TABLE_DEPTH) begin
                    wp_x[wp_count] = longint'(req.way_x);
                    wp_y[wp_count] = longint'(req.way_y);
                    wp_z[wp_count] = longint'(req.way_z);
                    wp_h[wp_count] = int'(req.way_heading);
                    wp_count++;
                end
            end
            OP_START: begin
                if (wp_count == 0 || running) begin
                    r.status = ST_REJECT;
                    has = 1'b1;
                end else begin
                    running = 1'b1;
                    cur_seg = 0;
                    sp_x = wp_x[0];
                    sp_y = wp_y[0];
                    sp_z = wp_z[0];
                    sp_h = wp_h[0];
                end
            end
            OP_CANCEL: begin
                if (running) begin
                    r = snapshot(ST_CANCEL);
                    has = 1'b1;
                end
                wp_count = 0;
                running  = 1'b0;
            end
            default: begin
                if (running) begin
                    dx = wp_x[cur_seg] - sp_x;
                    dy = wp_y[cur_seg] - sp_y;
                    dz = wp_z[cur_seg] - sp_z;
                    seg_len = distance3(dx, dy, dz);
                    yerr = fold_yaw(wp_h[cur_seg] - sp_h);
                    if (seg_len > step_len) begin
                        q = int'(mag64(longint'(yerr)) * step_len / seg_len);
                        sp_x = slide(sp_x, dx, seg_len);
                        sp_y = slide(sp_y, dy, seg_len);
                        sp_z = slide(sp_z, dz, seg_len);
                        sp_h += (yerr < 0) ? -q : q;
                    end else begin
                        sp_x = wp_x[cur_seg];
                        sp_y = wp_y[cur_seg];
                        sp_z = wp_z[cur_seg];
                        sp_h = wp_h[cur_seg];
                    end
                    sp_h = fold_yaw(sp_h);
                    perr = distance3(wp_x[cur_seg] - sp_x, wp_y[cur_seg] - sp_y,
                                     wp_z[cur_seg] - sp_z);
                    yabs = fold_yaw(wp_h[cur_seg] - sp_h);
                    if (yabs < 0) yabs = -yabs;
                    has = 1'b1;
                    if (perr <= pos_tol && longint'(yabs) <= yaw_tol) begin
                        if (cur_seg + 1 < wp_count) begin
                            cur_seg++;
                        end else begin
                            r = snapshot(ST_DONE);
                            wp_count = 0;
                            running  = 1'b0;
                            return;
                        end
                    end
                    r = snapshot(ST_PROGRESS);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (setpoint_q.size() == 0) begin
            report_mismatch("unexpected result, status", got.status, -1);
            return;
        end
        want = setpoint_q.pop_front();
        o_checked++;
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.active_index !== want.active_index)
            report_mismatch("active_index", got.active_index, want.active_index);
        if (got.target_x !== want.target_x)
            report_mismatch("target_x", got.target_x, want.target_x);
        if (got.target_y !== want.target_y)
            report_mismatch("target_y", got.target_y, want.target_y);
        if (got.target_z !== want.target_z)
            report_mismatch("target_z", got.target_z, want.target_z);
        if (got.target_heading !== want.target_heading)
            report_mismatch("target_heading", got.target_heading, want.target_heading);
        if (got.distance_to_goal !== want.distance_to_goal)
            report_mismatch("distance_to_goal", got.distance_to_goal, want.distance_to_goal);
    endtask

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_checked   = 0;
        o_path_busy = 1'b0;
    end

    always @(posedge i_clk) begin
        bit   has;
        t_out r;
        if (!i_rst_n) begin
            wp_count = 0;
            cur_seg  = 0;
            sp_x = 0; sp_y = 0; sp_z = 0; sp_h = 0;
            running  = 1'b0;
            step_len = 64'(STEP_RST);
            pos_tol  = 64'(PTOL_RST);
            yaw_tol  = 64'(YTOL_RST);
            setpoint_q.delete();
        end else begin
            if (o_valid && !i_stall) begin
                check_result(o_data);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STEP: step_len = 64'(i_cfg_data[30:0]);
                    CFG_PTOL: pos_tol  = 64'(i_cfg_data[30:0]);
                    CFG_YTOL: yaw_tol  = 64'(i_cfg_data[14:0]);
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                advance_setpoint(i_data, has, r);
                if (has) setpoint_q = {setpoint_q, r};
            end
        end
        o_pending   = setpoint_q.size();
        o_path_busy = running;
    end

endmodule

`default_nettype wire

FILE: dv/waypoint_setpoint_interpolator_top_tb.sv
// Testbench top: drives requests and register writes into the interpolator,
// varies stalls on both sides and gives the verdict.
// Depends on wsi_pkg, the interpolator RTL and wsi_setpoint_checker.
`default_nettype none

module waypoint_setpoint_interpolator_top_tb
    import wsi_pkg::*;
();

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 400;
    localparam int HOLD_LEN   = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int   err_count, pending, checked;
    logic path_busy;
    int   send_idle, recv_idle;
    int   hold_asks, holds_done;
    int   req_count, idle_cycles;

    waypoint_setpoint_interpolator_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    wsi_setpoint_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(err_count), .o_pending(pending), .o_checked(checked),
        .o_path_busy(path_busy)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        i_stall    = 1'b0;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_asks > holds_done) begin
                i_stall = 1'b1;
                repeat (HOLD_LEN) @(negedge i_clk);
                holds_done++;
            end
            i_stall = ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("** waypoint_setpoint_interpolator_top: FAILED **");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input t_in req);
        while ($urandom_range(99) < send_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = req;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        req_count++;
    endtask

    task automatic send_op(input logic [1:0] op, input int x, input int y, input int z,
                           input int h);
        t_in req;
        req.operation   = op;
        req.way_x       = x;
        req.way_y       = y;
        req.way_z       = z;
        req.way_heading = h[15:0];
        send_req(req);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_regs(input int unsigned step, input int unsigned ptol,
                            input int unsigned ytol);
        drain();
        write_reg(CFG_STEP, step);
        write_reg(CFG_PTOL, ptol);
        write_reg(CFG_YTOL, ytol);
    endtask

    function automatic int coord(input int scale);
        if (scale == 0) return int'($urandom);
        return int'($urandom_range(0, 2 * scale)) - scale;
    endfunction

    function automatic int heading();
        return int'($urandom_range(0, 51472)) - 25736;
    endfunction

    // clear, load, start and tick one path; cancel it if it runs too long
    task automatic random_path(input int scale, input int n_wp, input int max_ticks);
        send_op(OP_CANCEL, coord(0), coord(0), coord(0), coord(0));
        if ($urandom_range(15) == 0) begin
            send_op(OP_START, 0, 0, 0, 0);
        end
        for (int n = 0; n < n_wp; n++) begin
            send_op(OP_APPEND, coord(scale), coord(scale), coord(scale), heading());
        end
        send_op(OP_START, coord(0), coord(0), coord(0), coord(0));
        if ($urandom_range(7) == 0) begin
            send_op(OP_START, 0, 0, 0, 0);
        end
        for (int k = 0; k < max_ticks && path_busy; k++) begin
            send_op(OP_TICK, coord(0), coord(0), coord(0), coord(0));
        end
        if (path_busy) begin
            send_op(OP_CANCEL, 0, 0, 0, 0);
        end
    endtask

    task automatic run_phase(input int budget, input int scale, input int max_ticks);
        int stop_at;
        stop_at = req_count + budget;
        while (req_count < stop_at) begin
            case ($urandom_range(9))
                0: send_op(2'($urandom), coord(0), coord(0), coord(0), coord(0));
                1: random_path(0, $urandom_range(1, 4), max_ticks);
                default: random_path(scale, $urandom_range(1, 5), max_ticks);
            endcase
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_STEP;
        i_cfg_data  = '0;
        send_idle   = 38;
        recv_idle   = 58;
        hold_asks   = 0;
        req_count   = 0;
        idle_cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-table cases, extreme waypoints, out-of-range yaw
        send_op(OP_START, 0, 0, 0, 0);
        send_op(OP_TICK, 0, 0, 0, 0);
        send_op(OP_CANCEL, 0, 0, 0, 0);
        send_op(OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 25736);
        send_op(OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -25736);
        send_op(OP_START, 0, 0, 0, 0);
        send_op(OP_START, 0, 0, 0, 0);
        send_op(OP_APPEND, 1, 2, 3, 4);
        send_op(OP_TICK, -1, -1, -1, -1);
        send_op(OP_TICK, 0, 0, 0, 0);
        send_op(OP_CANCEL, 0, 0, 0, 0);
        send_op(OP_APPEND, 0, 0, 0, 32767);
        send_op(OP_APPEND, 6000, -3000, 100, -32768);
        send_op(OP_START, 0, 0, 0, 0);
        repeat (6) send_op(OP_TICK, 0, 0, 0, 0);
        send_op(OP_CANCEL, 0, 0, 0, 0);

        // zero step with tolerances wide open; then a full table
        set_regs(0, 31'h7FFF_FFFF, 25736);
        send_op(OP_APPEND, 5, 5, 5, 100);
        send_op(OP_APPEND, 70000, 0, 0, 0);
        send_op(OP_START, 0, 0, 0, 0);
        repeat (3) send_op(OP_TICK, 0, 0, 0, 0);
        for (int n = 0; n < 65; n++) begin
            send_op(OP_APPEND, coord(100000), coord(100000), coord(100000), heading());
        end
        send_op(OP_START, 0, 0, 0, 0);
        while (path_busy) send_op(OP_TICK, 0, 0, 0, 0);

        // sender 38 / receiver 58, with a long receiver hold-off
        send_idle = 38;
        recv_idle = 58;
        set_regs(6554, 6554, 819);
        run_phase(250, 131072, 80);
        hold_asks++;
        run_phase(250, 131072, 80);

        // sender 58 / receiver 38, with the sender pausing until drained
        send_idle = 58;
        recv_idle = 38;
        set_regs(31'h7FFF_FFFF, 0, 0);
        run_phase(200, 0, 20);
        drain();
        run_phase(200, 0, 20);

        send_idle = 0;
        recv_idle = 0;
        set_regs(0, 31'h7FFF_FFFF, 25736);
        run_phase(350, 1 << 20, 20);
        set_regs($urandom_range(2000, 300000), $urandom_range(0, 100000),
                 $urandom_range(0, 25736));
        run_phase(450, 1 << 19, 60);

        drain();
        $display("Sent %0d requests across six register settings and three stall mixes;",
                 req_count);
        $display("%0d results compared, %0d mismatches.", checked, err_count);
        if (err_count == 0 && pending == 0) begin
            $display("** waypoint_setpoint_interpolator_top: PASSED **");
        end else begin
            $display("** waypoint_setpoint_interpolator_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
